// ----- src/cdg_pkg.sv -----
package cdg_pkg;

  // Frame limits and derived widths
  localparam int MAX_COLS = 2048;
  localparam int MAX_ROWS = 2048;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int SIZE_W   = 12;
  localparam int PIX_W    = 8;
  localparam int GRAD_W   = 9;

  // Configuration register indexes
  localparam logic [1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [1:0] REG_FRAME_COLS = 2'd1;
  localparam logic [1:0] REG_DIRECTION  = 2'd2;

  localparam logic DIR_X = 1'b0;
  localparam logic DIR_Y = 1'b1;

  // Output queue sizing
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // One line memory entry: the pixel one row up and two rows up
  typedef struct packed {
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;
  } line_word_t;

  // One result beat
  typedef struct packed {
    logic                     frame_end;
    logic                     run_end;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
    logic signed [GRAD_W-1:0] gradient;
  } result_t;

  // Results pushed by the compute stage in one cycle
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  // Last index for a configured size, with the size saturated to 2..max
  function automatic logic [COL_W-1:0] last_index(input logic [SIZE_W-1:0] v,
                                                 input logic [SIZE_W-1:0] max_v);
    logic [SIZE_W-1:0] t;
    begin
      if (v < SIZE_W'(2)) begin
        t = SIZE_W'(1);
      end else if (v > max_v) begin
        t = max_v - SIZE_W'(1);
      end else begin
        t = v - SIZE_W'(1);
      end
      last_index = t[COL_W-1:0];
    end
  endfunction

endpackage

// ----- src/cdg_line_mem.sv -----
module cdg_line_mem (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [cdg_pkg::COL_W-1:0]    rd_addr,
  output cdg_pkg::line_word_t          rd_data,
  input  logic                         wr_en,
  input  logic [cdg_pkg::COL_W-1:0]    wr_addr,
  input  cdg_pkg::line_word_t          wr_data
);

  cdg_pkg::line_word_t mem [cdg_pkg::MAX_COLS];
  cdg_pkg::line_word_t rd_data_r;

  // Write the updated column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/cdg_out_queue.sv -----
module cdg_out_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cdg_pkg::push_t              push,
  output logic                        room,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cdg_pkg::result_t            out_data
);

  cdg_pkg::result_t                q_r [cdg_pkg::QDEPTH];
  logic [cdg_pkg::QPTR_W-1:0]      head_r, head_nxt;
  logic [cdg_pkg::QPTR_W-1:0]      tail_r, tail_nxt;
  logic [cdg_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;
  logic [cdg_pkg::QPTR_W-1:0]      tail_p1;
  logic                            pop;
  logic [1:0]                      npush;

  assign pop       = out_valid && out_ready;
  assign tail_p1   = tail_r + cdg_pkg::QPTR_W'(1);
  assign npush     = {1'b0, push.push0} + {1'b0, push.push1};
  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[head_r];

  // Keep room for one beat pair in flight plus one more pair
  assign room = (cnt_r <= cdg_pkg::QCNT_W'(cdg_pkg::QDEPTH - 4));

  // Advance pointers and count
  always_comb begin
    head_nxt = pop ? head_r + cdg_pkg::QPTR_W'(1) : head_r;
    tail_nxt = tail_r + cdg_pkg::QPTR_W'(npush);
    cnt_nxt  = cnt_r + cdg_pkg::QCNT_W'(npush) - cdg_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store pushed beats in order
  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_r[tail_r] <= push.res0;
      if (push.push1) begin
        q_r[tail_p1] <= push.res1;
      end
    end else if (push.push1) begin
      q_r[tail_r] <= push.res1;
    end
  end

endmodule

// ----- src/central_difference_gradient_unit.sv -----
// Central-difference gradient over a raster stream of 8-bit pixels. Each
// result is the plain difference of the two neighbors along X
// (direction 0) or Y (direction 1), i.e. the gradient in units of 0.5,
// with one-sided differences at frame edges. X results lag by one pixel,
// Y results by one row; the pixel that closes a row (X) or any pixel of
// the last row (Y) gives two beats. The two previous rows live in one
// 2048 x 16 line memory: a pixel reads its column when accepted and the
// column is written back the next cycle, so one pixel is taken per clock
// while the queue has room. Results drain through an 8-beat queue at one
// beat per clock while out_tready is high; the input is held off while
// more than four beats are queued, so streams with frequent double
// results settle at the output rate. Write the configuration only while
// the block is idle.
module central_difference_gradient_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [11:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [8:0] gradient, [19:9] out_row, [30:20] out_col
  output logic        out_tuser,   // run_end
  output logic        out_tlast    // frame_end
);

  localparam int PW = cdg_pkg::PIX_W;
  localparam int CW = cdg_pkg::COL_W;
  localparam int RW = cdg_pkg::ROW_W;
  localparam int SW = cdg_pkg::SIZE_W;
  localparam int GW = cdg_pkg::GRAD_W;

  // Configuration
  logic [SW-1:0] frame_rows_r;
  logic [SW-1:0] frame_cols_r;
  logic          direction_r;

  // Stream position and pixel history
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [PW-1:0] prev0_r, prev1_r;

  // Compute stage
  logic          s1_vld_r;
  logic [PW-1:0] s1_px_r, s1_prev0_r, s1_prev1_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_lcol_r, s1_lrow_r, s1_dir_r;

  logic               accept;
  logic               room;
  logic [CW-1:0]      col_last;
  logic [RW-1:0]      row_last;
  logic               last_col, last_row;
  cdg_pkg::line_word_t rd_word, wr_word;
  cdg_pkg::push_t     push;
  cdg_pkg::result_t   q_data;

  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r <= SW'(480);
      frame_cols_r <= SW'(640);
      direction_r  <= cdg_pkg::DIR_X;
    end else if (cfg_we) begin
      case (cfg_addr)
        cdg_pkg::REG_FRAME_ROWS: frame_rows_r <= cfg_wdata;
        cdg_pkg::REG_FRAME_COLS: frame_cols_r <= cfg_wdata;
        cdg_pkg::REG_DIRECTION:  direction_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Frame edge detection, saturated sizes
  assign col_last = cdg_pkg::last_index(frame_cols_r, SW'(cdg_pkg::MAX_COLS));
  assign row_last = cdg_pkg::last_index(frame_rows_r, SW'(cdg_pkg::MAX_ROWS));
  assign last_col = (col_r >= col_last);
  assign last_row = (row_r >= row_last);

  // Advance the raster position
  always_comb begin
    col_nxt = col_r + CW'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= '0;
      col_r    <= '0;
      prev0_r  <= '0;
      prev1_r  <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
      if (accept) begin
        row_r   <= row_nxt;
        col_r   <= col_nxt;
        prev0_r <= in_tdata;
        prev1_r <= prev0_r;
      end
    end
  end

  // Hold the accepted pixel for the compute stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r    <= in_tdata;
      s1_prev0_r <= prev0_r;
      s1_prev1_r <= prev1_r;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_lcol_r  <= last_col;
      s1_lrow_r  <= last_row;
      s1_dir_r   <= direction_r;
    end
  end

  // Line memory: read on accept, write back next cycle
  assign wr_word.two_above = rd_word.above;
  assign wr_word.above     = s1_px_r;

  cdg_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (rd_word),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_col_r),
    .wr_data (wr_word)
  );

  // Form results
  always_comb begin
    logic [PW-1:0] ref0;
    logic [PW-1:0] ref1;
    ref0 = '0;
    ref1 = '0;
    push = '0;
    if (s1_dir_r == cdg_pkg::DIR_X) begin
      ref0 = (s1_col_r == CW'(1)) ? s1_prev0_r : s1_prev1_r;
      ref1 = s1_prev0_r;
      push.push0 = s1_vld_r && (s1_col_r != '0);
      push.push1 = s1_vld_r && (s1_col_r != '0) && s1_lcol_r;
      push.res0.row       = s1_row_r;
      push.res0.col       = s1_col_r - CW'(1);
      push.res0.run_end   = !s1_lcol_r;
      push.res1.frame_end = s1_lrow_r;
    end else begin
      ref0 = (s1_row_r == RW'(1)) ? rd_word.above : rd_word.two_above;
      ref1 = rd_word.above;
      push.push0 = s1_vld_r && (s1_row_r != '0);
      push.push1 = s1_vld_r && (s1_row_r != '0) && s1_lrow_r;
      push.res0.row       = s1_row_r - RW'(1);
      push.res0.col       = s1_col_r;
      push.res0.run_end   = !s1_lrow_r;
      push.res1.frame_end = s1_lcol_r;
    end
    push.res0.gradient  = $signed({1'b0, s1_px_r}) - $signed({1'b0, ref0});
    push.res0.frame_end = 1'b0;
    push.res1.gradient  = $signed({1'b0, s1_px_r}) - $signed({1'b0, ref1});
    push.res1.row       = s1_row_r;
    push.res1.col       = s1_col_r;
    push.res1.run_end   = 1'b1;
  end

  cdg_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  // Pack the result beat
  assign out_tdata = {1'b0, q_data.col, q_data.row, q_data.gradient[GW-1:0]};
  assign out_tuser = q_data.run_end;
  assign out_tlast = q_data.frame_end;

endmodule

// ----- bench/central_difference_gradient_unit_test.sv -----
module central_difference_gradient_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 550;
  localparam int CALM_PIXELS   = 150;

  // One gradient beat as it leaves the block
  typedef struct packed {
    logic signed [cdg_pkg::GRAD_W-1:0] gradient;
    logic [cdg_pkg::ROW_W-1:0]         row;
    logic [cdg_pkg::COL_W-1:0]         col;
    logic                              run_end;
    logic                              frame_end;
  } grad_beat_t;

  // One row of the directed stimulus: a register write or a pixel
  typedef struct {
    bit                          is_cfg;
    logic [1:0]                  idx;
    logic [cdg_pkg::SIZE_W-1:0]  val;
    logic [cdg_pkg::PIX_W-1:0]   pix;
    int                          n_typed;   // -1: take the beats from the predictor
    grad_beat_t                  b0;
    grad_beat_t                  b1;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [11:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  central_difference_gradient_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pixel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [8:0] gradient, [19:9] out_row, [30:20] out_col
    .out_tuser  (out_tuser),   // run_end
    .out_tlast  (out_tlast)    // frame_end
  );

  // Predictor state: registers, stream position, pixel and line history
  logic [cdg_pkg::SIZE_W-1:0] cfg_rows = cdg_pkg::SIZE_W'(480);
  logic [cdg_pkg::SIZE_W-1:0] cfg_cols = cdg_pkg::SIZE_W'(640);
  logic                       cfg_dir  = cdg_pkg::DIR_X;
  int                         pos_row = 0;
  int                         pos_col = 0;
  int                         prev_px [2] = '{0, 0};
  logic [cdg_pkg::PIX_W-1:0]  line_above     [cdg_pkg::MAX_COLS];
  logic [cdg_pkg::PIX_W-1:0]  line_two_above [cdg_pkg::MAX_COLS];
  grad_beat_t                 pred_beats [2];

  grad_beat_t gradients_due [$];
  stim_row_t  plan [$];
  int         fail_count = 0;
  int         pixels_sent = 0;
  int         cycle_count = 0;
  bit         src_gaps = 1'b1;
  bit         calm = 1'b0;

  // Clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int size_in_use(input logic [cdg_pkg::SIZE_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic grad_beat_t make_beat(input int g, input int r, input int c,
                                           input bit re, input bit fe);
    grad_beat_t b;
    b.gradient  = cdg_pkg::GRAD_W'(g);
    b.row       = cdg_pkg::ROW_W'(r);
    b.col       = cdg_pkg::COL_W'(c);
    b.run_end   = re;
    b.frame_end = fe;
    return b;
  endfunction

  // Work out the beats one pixel causes and advance the stream position
  function automatic int predict_gradients(input logic [cdg_pkg::PIX_W-1:0] px);
    int  rows_eff, cols_eff, pv, above, two_above, n;
    bit  last_col, last_row;
    rows_eff  = size_in_use(cfg_rows, cdg_pkg::MAX_ROWS);
    cols_eff  = size_in_use(cfg_cols, cdg_pkg::MAX_COLS);
    pv        = int'(px);
    last_col  = (pos_col >= cols_eff - 1);
    last_row  = (pos_row >= rows_eff - 1);
    above     = int'(line_above[pos_col]);
    two_above = int'(line_two_above[pos_col]);
    n = 0;
    if (cfg_dir == cdg_pkg::DIR_X) begin
      // previous column's beat, then the closing column one-sided
      if (pos_col > 0) begin
        pred_beats[n] = make_beat(pv - ((pos_col == 1) ? prev_px[0] : prev_px[1]),
                                  pos_row, pos_col - 1, !last_col, 1'b0);
        n++;
        if (last_col) begin
          pred_beats[n] = make_beat(pv - prev_px[0], pos_row, pos_col, 1'b1, last_row);
          n++;
        end
      end
    end else begin
      // previous row's beat, then the final row one-sided
      if (pos_row > 0) begin
        pred_beats[n] = make_beat(pv - ((pos_row == 1) ? above : two_above),
                                  pos_row - 1, pos_col, !last_row, 1'b0);
        n++;
        if (last_row) begin
          pred_beats[n] = make_beat(pv - above, pos_row, pos_col, 1'b1, last_col);
          n++;
        end
      end
    end
    // History is kept in both directions
    prev_px[1] = prev_px[0];
    prev_px[0] = pv;
    line_two_above[pos_col] = cdg_pkg::PIX_W'(above);
    line_above[pos_col]     = px;
    if (last_col) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col++;
    end
    return n;
  endfunction

  // Pixels left until the current frame closes
  function automatic int pixels_to_frame_end();
    int r_eff, c_eff, n;
    r_eff = size_in_use(cfg_rows, cdg_pkg::MAX_ROWS);
    c_eff = size_in_use(cfg_cols, cdg_pkg::MAX_COLS);
    n = (pos_col >= c_eff - 1) ? 1 : c_eff - pos_col;
    if (pos_row < r_eff - 1) n += (r_eff - 1 - pos_row) * c_eff;
    return n;
  endfunction

  function automatic logic [cdg_pkg::PIX_W-1:0] rand_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
    return cdg_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [cdg_pkg::SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return cdg_pkg::SIZE_W'($urandom_range(0, 1));
    if (sel <= 2) return cdg_pkg::SIZE_W'($urandom_range(13, 32));
    return cdg_pkg::SIZE_W'($urandom_range(2, 12));
  endfunction

  function automatic void plan_cfg(input logic [1:0] idx,
                                   input logic [cdg_pkg::SIZE_W-1:0] val);
    stim_row_t s;
    s = '{is_cfg: 1'b1, idx: idx, val: val, pix: '0, n_typed: 0, b0: '0, b1: '0};
    plan.push_back(s);
  endfunction

  function automatic void plan_px(input logic [cdg_pkg::PIX_W-1:0] p, input int n = -1,
                                  input grad_beat_t b0 = '0, input grad_beat_t b1 = '0);
    stim_row_t s;
    s = '{is_cfg: 1'b0, idx: '0, val: '0, pix: p, n_typed: n, b0: b0, b1: b1};
    plan.push_back(s);
  endfunction

  task automatic note_mismatch(input string what, input grad_beat_t want,
                               input grad_beat_t seen);
    if (fail_count < 10) begin
      $write("%s: expected grad %0d row %0d col %0d run_end %0b frame_end %0b, ",
             what, want.gradient, want.row, want.col, want.run_end, want.frame_end);
      $display("got grad %0d row %0d col %0d run_end %0b frame_end %0b",
               seen.gradient, seen.row, seen.col, seen.run_end, seen.frame_end);
    end
    fail_count++;
  endtask

  // Hold the input off until every expected beat is out and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (gradients_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [cdg_pkg::SIZE_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cdg_pkg::REG_FRAME_ROWS: cfg_rows = val;
      cdg_pkg::REG_FRAME_COLS: cfg_cols = val;
      cdg_pkg::REG_DIRECTION:  cfg_dir  = val[0];
      default: ;
    endcase
  endtask

  // Send one pixel beat, then queue what it should produce
  task automatic drive_pixel(input logic [cdg_pkg::PIX_W-1:0] p, input int n_typed,
                             input grad_beat_t b0, input grad_beat_t b1);
    int n;
    if (src_gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    n = predict_gradients(p);
    if (n_typed < 0) begin
      for (int k = 0; k < n; k++) gradients_due.push_back(pred_beats[k]);
    end else begin
      if (n_typed > 0) gradients_due.push_back(b0);
      if (n_typed > 1) gradients_due.push_back(b1);
    end
  endtask

  task automatic send_pixels(input int count);
    for (int k = 0; k < count; k++) drive_pixel(rand_pixel(), -1, '0, '0);
  endtask

  // One frame setting: whole frames mostly, sometimes a frame cut and altered
  task automatic random_phase();
    int frame_px, cut, pick, c_eff;
    src_gaps = ($urandom_range(0, 2) != 0);
    write_reg(cdg_pkg::REG_FRAME_ROWS, pick_size());
    write_reg(cdg_pkg::REG_FRAME_COLS, (size_in_use(cfg_rows, cdg_pkg::MAX_ROWS) > 12) ?
              cdg_pkg::SIZE_W'($urandom_range(2, 8)) : pick_size());
    write_reg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'($urandom_range(0, 1)));
    frame_px = pixels_to_frame_end();
    if ($urandom_range(0, 9) < 8) begin
      send_pixels(frame_px * $urandom_range(1, 2));
    end else begin
      cut = $urandom_range(1, frame_px - 1);
      send_pixels(cut);
      pick  = $urandom_range(0, 3);
      c_eff = size_in_use(cfg_cols, cdg_pkg::MAX_COLS);
      // widen the row only in X, where no stale line entry gets read
      if (pick == 0) begin
        write_reg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(!cfg_dir));
      end else if (pick == 1) begin
        write_reg(cdg_pkg::REG_FRAME_ROWS, cdg_pkg::SIZE_W'($urandom_range(0, 12)));
      end else if (pick == 2 || cfg_dir == cdg_pkg::DIR_Y) begin
        write_reg(cdg_pkg::REG_FRAME_COLS, cdg_pkg::SIZE_W'($urandom_range(0, c_eff)));
      end else begin
        write_reg(cdg_pkg::REG_FRAME_COLS, cdg_pkg::SIZE_W'(c_eff + $urandom_range(1, 8)));
      end
      send_pixels(pixels_to_frame_end());
    end
  endtask

  // Backpressure on the result side: stretches with and without stalls
  initial begin : result_sink
    int stretch;
    bit stall_on;
    stretch  = 0;
    stall_on = 1'b0;
    forever begin
      @(posedge clk);
      if (stretch == 0) begin
        stall_on = $urandom_range(0, 1);
        stretch  = $urandom_range(20, 200);
      end
      stretch--;
      if (!calm && stall_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_beats
    grad_beat_t seen, want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.gradient  = out_tdata[8:0];
      seen.row       = out_tdata[19:9];
      seen.col       = out_tdata[30:20];
      seen.run_end   = out_tuser;
      seen.frame_end = out_tlast;
      if (gradients_due.size() == 0) begin
        note_mismatch("unexpected beat", '0, seen);
      end else begin
        want = gradients_due.pop_front();
        if (seen !== want) note_mismatch("beat mismatch", want, seen);
      end
    end
  end

  initial begin : stimulus
    int rand_goal;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Smallest X frame with full-scale steps, sizes below the minimum
    plan_cfg(cdg_pkg::REG_FRAME_ROWS, 12'd0);
    plan_cfg(cdg_pkg::REG_FRAME_COLS, 12'd1);
    plan_cfg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_X));
    plan_px(8'd0, 0);
    plan_px(8'd255, 2, make_beat(255, 0, 0, 0, 0), make_beat(255, 0, 1, 1, 0));
    plan_px(8'd255, 0);
    plan_px(8'd0, 2, make_beat(-255, 1, 0, 0, 0), make_beat(-255, 1, 1, 1, 1));
    // Same in Y: first row gives nothing, last row gives two beats
    plan_cfg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_Y));
    plan_px(8'd0, 0);
    plan_px(8'd255, 0);
    plan_px(8'd255, 2, make_beat(255, 0, 0, 0, 0), make_beat(255, 1, 0, 1, 0));
    plan_px(8'd0, 2, make_beat(-255, 0, 1, 0, 0), make_beat(-255, 1, 1, 1, 1));
    // 3x3 in Y: a true central difference in the middle row
    plan_cfg(cdg_pkg::REG_FRAME_ROWS, 12'd3);
    plan_cfg(cdg_pkg::REG_FRAME_COLS, 12'd3);
    plan_px(8'd17);
    plan_px(8'd200);
    plan_px(8'd90);
    plan_px(8'd45);
    plan_px(8'd128);
    plan_px(8'd3);
    plan_px(8'd250);
    plan_px(8'd64);
    plan_px(8'd111);
    // 3x3 in X, switched to Y mid-frame, then narrowed under the last row
    plan_cfg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_X));
    plan_px(8'd9);
    plan_px(8'd180);
    plan_px(8'd33);
    plan_px(8'd77);
    plan_cfg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_Y));
    plan_px(8'd140);
    plan_px(8'd6);
    plan_px(8'd222);
    plan_cfg(cdg_pkg::REG_FRAME_COLS, 12'd2);
    plan_px(8'd58);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        drive_pixel(plan[i].pix, plan[i].n_typed, plan[i].b0, plan[i].b1);
      end
    end

    // Widest row setting, cut short past the upper column bit by shrinking the width
    write_reg(cdg_pkg::REG_FRAME_ROWS, 12'd1);
    write_reg(cdg_pkg::REG_FRAME_COLS, 12'd2048);
    write_reg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_X));
    send_pixels(cdg_pkg::MAX_COLS / 2 + 6);
    write_reg(cdg_pkg::REG_FRAME_COLS, 12'd0);
    send_pixels(pixels_to_frame_end());
    // Oversized height in Y, then cut short by shrinking the height
    write_reg(cdg_pkg::REG_FRAME_ROWS, 12'd4095);
    write_reg(cdg_pkg::REG_FRAME_COLS, 12'd2);
    write_reg(cdg_pkg::REG_DIRECTION, cdg_pkg::SIZE_W'(cdg_pkg::DIR_Y));
    send_pixels(41);
    write_reg(cdg_pkg::REG_FRAME_ROWS, 12'd6);
    send_pixels(pixels_to_frame_end());

    // Random frames; the tail runs without idling on either side
    rand_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < rand_goal) begin
      calm = (pixels_sent + CALM_PIXELS >= rand_goal);
      random_phase();
    end

    settle();
    if (fail_count == 0 && gradients_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- central_difference_gradient_unit.f -----
src/cdg_pkg.sv
src/cdg_line_mem.sv
src/cdg_out_queue.sv
src/central_difference_gradient_unit.sv
bench/central_difference_gradient_unit_test.sv
